// ----- rtl/core/tsp_pkg.sv -----
// Shared types, constants and helpers for the trapezoidal speed profile block.
package tsp_pkg;

    localparam int ENC_W   = 16;
    localparam int DIST_W  = 17;
    localparam int RAMP_W  = 16;
    localparam int PEAK_W  = 8;
    localparam int SPD_W   = 21;
    localparam int SUM_W   = SPD_W + 1;
    localparam int DUTY_W  = 10;
    localparam int DVS_W   = RAMP_W + 1;
    localparam int PCT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int OUT_W   = SPD_W + 1 + DUTY_W;

    localparam int PCT_MAX     = 100;
    localparam int FLOOR_PCT   = 10;
    localparam int SPD_POS_LIM = 1048575;
    localparam int SPD_NEG_LIM = 1048576;

    localparam logic signed [SPD_W-1:0] SPD_MAX_V = 21'sh0FFFFF;
    localparam logic signed [SPD_W-1:0] SPD_MIN_V = 21'sh100000;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DIST      = 2'd0;
    localparam logic [1:0] REG_RAMP_UP   = 2'd1;
    localparam logic [1:0] REG_RAMP_DOWN = 2'd2;
    localparam logic [1:0] REG_PEAK      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_USTART,
        S_UWAIT,
        S_URATE,
        S_UADD,
        S_EVAL,
        S_APPLY,
        S_PADD,
        S_DWAIT,
        S_DRATE,
        S_DFLOOR,
        S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        PH_UP,
        PH_CRUISE,
        PH_DOWN,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic latch_enc;
        logic setup;
        logic div_start;
        logic div_down;
        logic load_rate;
        logic snap;
        logic add_rate;
        logic cruise;
        logic floor_step;
        logic eval;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic   div_busy;
        t_phase phase;
        logic   out_free;
    } t_status;

    // Signed add that saturates to the speed range.
    function automatic logic signed [SPD_W-1:0] sat_add(
        input logic signed [SPD_W-1:0] a,
        input logic signed [SPD_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s[SUM_W-1] != s[SUM_W-2]) begin
            return s[SUM_W-1] ? SPD_MIN_V : SPD_MAX_V;
        end
        return s[SPD_W-1:0];
    endfunction

endpackage

// ----- rtl/core/tsp_div.sv -----
// Radix-2 restoring divider for the ramp rate, one quotient bit per cycle.
module tsp_div #(
    parameter int DVD_W = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DVD_W-1:0]           i_dividend,
    input  logic [tsp_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [DVD_W-1:0]           o_quot
);
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int DW    = tsp_pkg::DVS_W;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]   w_rem_sh;
    logic [DW+1:0] w_diff;
    logic          w_fits;

    // The dividend shifts out of the top of r_quo as quotient bits shift in.
    assign w_rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dvs};
    assign w_fits   = !w_diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

// ----- rtl/core/tsp_datapath.sv -----
// Datapath: move state, phase evaluation, speed arithmetic, duty table and result register.
module tsp_datapath #(
    parameter int DUTY_FULL = 1023,
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tsp_pkg::t_cmd                      i_cmd,
    output tsp_pkg::t_status                   o_stat,
    input  logic signed [tsp_pkg::ENC_W-1:0]   i_enc,
    input  logic signed [tsp_pkg::DIST_W-1:0]  i_dist,
    input  logic [tsp_pkg::RAMP_W-1:0]         i_ramp_up,
    input  logic [tsp_pkg::RAMP_W-1:0]         i_ramp_down,
    input  logic signed [tsp_pkg::PEAK_W-1:0]  i_peak,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [tsp_pkg::DATA_W-1:0]         o_m_tdata,
    output logic                               o_m_tlast
);
    localparam int DVD_W = 11 + FRAC_BITS;
    localparam int PQ_W  = tsp_pkg::PEAK_W + FRAC_BITS;
    localparam int PW    = (PQ_W > 22) ? PQ_W : 22;
    localparam int QW    = (DVD_W > 21) ? DVD_W : 21;
    localparam int SW    = tsp_pkg::SPD_W;
    localparam logic signed [SW-1:0] FLOOR_Q = SW'(tsp_pkg::FLOOR_PCT << FRAC_BITS);

    logic signed [tsp_pkg::ENC_W-1:0] r_enc;
    logic signed [tsp_pkg::ENC_W-1:0] r_start;
    logic signed [SW-1:0]             r_speed;
    logic signed [SW-1:0]             r_rate;
    logic [tsp_pkg::RAMP_W-1:0]       r_eff_up;
    logic [tsp_pkg::RAMP_W-1:0]       r_eff_down;
    logic                             r_div_down;
    logic [tsp_pkg::DUTY_W-1:0]       r_res_duty;
    logic                             r_res_dir;
    logic signed [SW-1:0]             r_res_speed;
    tsp_pkg::t_phase                  r_phase;
    logic                             r_out_valid;
    logic [tsp_pkg::OUT_W-1:0]        r_out_data;
    logic                             r_out_last;

    logic [tsp_pkg::DIST_W-1:0]       w_total;
    logic [tsp_pkg::DIST_W-1:0]       w_ramp_sum;
    logic [tsp_pkg::RAMP_W-1:0]       w_half;
    logic signed [tsp_pkg::DIST_W-1:0] w_prog_diff;
    logic [tsp_pkg::DIST_W-1:0]       w_prog;
    logic signed [tsp_pkg::DIST_W:0]  w_mid_diff;
    logic [tsp_pkg::DIST_W:0]         w_mid;
    tsp_pkg::t_phase                  w_phase;
    logic [tsp_pkg::PEAK_W-1:0]       w_peak_mag;
    logic [10:0]                      w_peak10;
    logic [DVD_W-1:0]                 w_dividend;
    logic [tsp_pkg::DVS_W-1:0]        w_divisor;
    logic                             w_div_busy;
    logic [DVD_W-1:0]                 w_quot;
    logic [QW-1:0]                    w_q_ext;
    logic                             w_rate_neg;
    logic signed [SW-1:0]             w_rate_new;
    logic signed [PQ_W-1:0]           w_pq;
    logic signed [PW-1:0]             w_pq_w;
    logic [PQ_W-1:0]                  w_pq_mag;
    logic signed [SW-1:0]             w_psat;
    logic [SW-1:0]                    w_spd_mag;
    logic signed [SW-1:0]             w_floor_val;
    logic signed [SW-1:0]             w_spd_plus;
    logic [SW-1:0]                    w_pct_raw;
    logic [tsp_pkg::PCT_W-1:0]        w_pct;
    logic [tsp_pkg::DUTY_W-1:0]       w_duty_tab [0:tsp_pkg::PCT_MAX];

    // Duty for each whole percent, worked out at elaboration.
    for (genvar k = 0; k <= tsp_pkg::PCT_MAX; k++) begin : g_duty
        localparam int DV = DUTY_FULL - (k * DUTY_FULL) / tsp_pkg::PCT_MAX;
        assign w_duty_tab[k] = tsp_pkg::DUTY_W'(DV);
    end

    // Move geometry. Both halving cases take half of the magnitude.
    assign w_total    = i_dist[tsp_pkg::DIST_W-1] ? tsp_pkg::DIST_W'(-i_dist)
                                                  : tsp_pkg::DIST_W'(i_dist);
    assign w_ramp_sum = tsp_pkg::DIST_W'(i_ramp_up) + tsp_pkg::DIST_W'(i_ramp_down);
    assign w_half     = w_total[tsp_pkg::DIST_W-1:1];

    assign w_prog_diff = tsp_pkg::DIST_W'(r_enc) - tsp_pkg::DIST_W'(r_start);
    assign w_prog      = w_prog_diff[tsp_pkg::DIST_W-1] ? tsp_pkg::DIST_W'(-w_prog_diff)
                                                        : tsp_pkg::DIST_W'(w_prog_diff);
    assign w_mid_diff  = $signed({1'b0, w_total}) - $signed({2'b00, r_eff_down});
    assign w_mid       = w_mid_diff[tsp_pkg::DIST_W] ? (tsp_pkg::DIST_W+1)'(-w_mid_diff)
                                                     : (tsp_pkg::DIST_W+1)'(w_mid_diff);

    always_comb begin
        if (w_prog < r_eff_up) begin
            w_phase = tsp_pkg::PH_UP;
        end else if ({1'b0, w_prog} < w_mid) begin
            w_phase = tsp_pkg::PH_CRUISE;
        end else if (w_prog < w_total) begin
            w_phase = tsp_pkg::PH_DOWN;
        end else begin
            w_phase = tsp_pkg::PH_DONE;
        end
    end

    // Dividend is |peak| * 10 in the speed's fixed point.
    assign w_peak_mag = i_peak[tsp_pkg::PEAK_W-1] ? tsp_pkg::PEAK_W'(-i_peak)
                                                  : tsp_pkg::PEAK_W'(i_peak);
    assign w_peak10   = (11'(w_peak_mag) << 3) + (11'(w_peak_mag) << 1);
    assign w_dividend = DVD_W'(w_peak10) << FRAC_BITS;
    assign w_divisor  = (i_cmd.div_down ? tsp_pkg::DVS_W'(r_eff_down)
                                        : tsp_pkg::DVS_W'(r_eff_up)) + tsp_pkg::DVS_W'(1);

    tsp_div #(
        .DVD_W(DVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // The ramp-down rate carries the opposite sign of the peak.
    assign w_q_ext    = QW'(w_quot);
    assign w_rate_neg = r_div_down ^ i_peak[tsp_pkg::PEAK_W-1];
    always_comb begin
        if (w_rate_neg) begin
            w_rate_new = (w_q_ext > QW'(tsp_pkg::SPD_NEG_LIM)) ? tsp_pkg::SPD_MIN_V
                                                               : SW'(-w_q_ext);
        end else begin
            w_rate_new = (w_q_ext > QW'(tsp_pkg::SPD_POS_LIM)) ? tsp_pkg::SPD_MAX_V
                                                               : SW'(w_q_ext);
        end
    end

    assign w_pq     = PQ_W'(i_peak) <<< FRAC_BITS;
    assign w_pq_w   = PW'(w_pq);
    assign w_pq_mag = w_pq[PQ_W-1] ? PQ_W'(-w_pq) : PQ_W'(w_pq);
    always_comb begin
        if (w_pq_w > PW'(tsp_pkg::SPD_POS_LIM)) begin
            w_psat = tsp_pkg::SPD_MAX_V;
        end else if (w_pq_w < -PW'(tsp_pkg::SPD_NEG_LIM)) begin
            w_psat = tsp_pkg::SPD_MIN_V;
        end else begin
            w_psat = SW'(w_pq_w);
        end
    end

    assign w_spd_mag  = r_speed[SW-1] ? SW'(-r_speed) : SW'(r_speed);
    assign w_spd_plus = tsp_pkg::sat_add(r_speed, r_rate);

    always_comb begin
        if (i_peak > 0) begin
            w_floor_val = FLOOR_Q;
        end else if (i_peak < 0) begin
            w_floor_val = -FLOOR_Q;
        end else begin
            w_floor_val = '0;
        end
    end

    // Truncation toward zero is a shift of the magnitude.
    assign w_pct_raw = w_spd_mag >> FRAC_BITS;
    assign w_pct     = (w_pct_raw > SW'(tsp_pkg::PCT_MAX)) ? tsp_pkg::PCT_W'(tsp_pkg::PCT_MAX)
                                                           : tsp_pkg::PCT_W'(w_pct_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_speed    <= '0;
            r_rate     <= '0;
            r_eff_up   <= '0;
            r_eff_down <= '0;
        end else begin
            if (i_cmd.setup) begin
                r_start <= r_enc;
                if (i_dist[tsp_pkg::DIST_W-1] || (w_ramp_sum > $unsigned(i_dist))) begin
                    r_eff_up   <= w_half;
                    r_eff_down <= w_half;
                end else begin
                    r_eff_up   <= i_ramp_up;
                    r_eff_down <= i_ramp_down;
                end
            end
            if (i_cmd.load_rate) begin
                r_rate <= w_rate_new;
            end
            if (i_cmd.add_rate) begin
                r_speed <= w_spd_plus;
            end else if (i_cmd.snap) begin
                if (PW'(w_spd_mag) > PW'(w_pq_mag)) begin
                    r_speed <= w_psat;
                end
            end else if (i_cmd.cruise) begin
                r_speed <= w_psat;
            end else if (i_cmd.floor_step) begin
                r_speed <= (w_spd_mag <= SW'(FLOOR_Q)) ? w_floor_val : w_spd_plus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_enc) begin
            r_enc <= i_enc;
        end
        if (i_cmd.div_start) begin
            r_div_down <= i_cmd.div_down;
        end
        if (i_cmd.eval) begin
            r_res_duty  <= w_duty_tab[w_pct];
            r_res_dir   <= r_speed[SW-1] || (w_pct_raw == '0);
            r_res_speed <= r_speed;
            r_phase     <= w_phase;
        end
        if (i_cmd.push) begin
            r_out_data <= {r_res_speed, r_res_dir, r_res_duty};
            r_out_last <= (r_phase == tsp_pkg::PH_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.div_busy = w_div_busy;
    assign o_stat.phase    = r_phase;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = tsp_pkg::DATA_W'(r_out_data);
    assign o_m_tlast  = r_out_last;

endmodule

// ----- rtl/core/tsp_ctrl.sv -----
// Controller: sequences one tick through move start, phase update and result hand-off.
module tsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  tsp_pkg::t_status i_stat,
    output tsp_pkg::t_cmd    o_cmd
);
    tsp_pkg::t_state r_state;
    tsp_pkg::t_state n_state;
    logic            r_starting;
    logic            n_starting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tsp_pkg::S_IDLE;
            r_starting <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_starting <= n_starting;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_starting = r_starting;
        unique case (r_state)
            tsp_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = r_starting ? tsp_pkg::S_SETUP : tsp_pkg::S_EVAL;
                end
            end
            tsp_pkg::S_SETUP: begin
                n_state    = tsp_pkg::S_USTART;
                n_starting = 1'b0;
            end
            tsp_pkg::S_USTART: n_state = tsp_pkg::S_UWAIT;
            tsp_pkg::S_UWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = tsp_pkg::S_URATE;
                end
            end
            tsp_pkg::S_URATE:  n_state = tsp_pkg::S_UADD;
            tsp_pkg::S_UADD:   n_state = tsp_pkg::S_EVAL;
            tsp_pkg::S_EVAL:   n_state = tsp_pkg::S_APPLY;
            tsp_pkg::S_APPLY: begin
                unique case (i_stat.phase)
                    tsp_pkg::PH_UP:     n_state = tsp_pkg::S_PADD;
                    tsp_pkg::PH_CRUISE: n_state = tsp_pkg::S_PUSH;
                    tsp_pkg::PH_DOWN:   n_state = tsp_pkg::S_DWAIT;
                    tsp_pkg::PH_DONE: begin
                        n_state    = tsp_pkg::S_PUSH;
                        n_starting = 1'b1;
                    end
                endcase
            end
            tsp_pkg::S_PADD:   n_state = tsp_pkg::S_PUSH;
            tsp_pkg::S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = tsp_pkg::S_DRATE;
                end
            end
            tsp_pkg::S_DRATE:  n_state = tsp_pkg::S_DFLOOR;
            tsp_pkg::S_DFLOOR: n_state = tsp_pkg::S_PUSH;
            tsp_pkg::S_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = tsp_pkg::S_IDLE;
                end
            end
            default: n_state = tsp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state) inside
            tsp_pkg::S_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.latch_enc = i_s_tvalid;
            end
            tsp_pkg::S_SETUP:  o_cmd.setup     = 1'b1;
            tsp_pkg::S_USTART: o_cmd.div_start = 1'b1;
            tsp_pkg::S_URATE:  o_cmd.load_rate = 1'b1;
            tsp_pkg::S_UADD:   o_cmd.add_rate  = 1'b1;
            tsp_pkg::S_EVAL:   o_cmd.eval      = 1'b1;
            tsp_pkg::S_APPLY: begin
                unique case (i_stat.phase)
                    tsp_pkg::PH_UP:     o_cmd.snap   = 1'b1;
                    tsp_pkg::PH_CRUISE: o_cmd.cruise = 1'b1;
                    tsp_pkg::PH_DOWN: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_down  = 1'b1;
                    end
                    tsp_pkg::PH_DONE: ;
                endcase
            end
            tsp_pkg::S_PADD:   o_cmd.add_rate   = 1'b1;
            tsp_pkg::S_DRATE:  o_cmd.load_rate  = 1'b1;
            tsp_pkg::S_DFLOOR: o_cmd.floor_step = 1'b1;
            tsp_pkg::S_PUSH:   o_cmd.push       = i_stat.out_free;
            tsp_pkg::S_UWAIT, tsp_pkg::S_DWAIT: ;
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/trapezoid_speed_profile.sv -----
// Top level of the trapezoidal speed profile: register port, controller and datapath.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[15:0] encoder_position
//  m_axis    out        tdata[9:0] pwm_duty, [10] drive_direction, [31:11] speed_now;
//                       tlast move_done
//  APB       in/out     move_distance, ramp_up_length, ramp_down_length, peak_speed
//
// One tick is handled at a time. A cruise tick runs EVAL, APPLY and PUSH after accept,
// a ramp-up tick adds PADD, and a ramp-down tick starts the radix-2 rate divider in APPLY,
// waits for it in DWAIT, then runs DRATE and DFLOOR before PUSH; the first tick of a move
// first runs SETUP, USTART, UWAIT, URATE and UADD. Reset is synchronous and active low and
// starts a new move. A stalled result waits in the output register while the next
// beat is already taken in.
module trapezoid_speed_profile #(
    parameter int DUTY_FULL = 1023,
    parameter int FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tsp_pkg::ENC_W-1:0]     s_axis_tdata,   // [15:0] encoder_position
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tsp_pkg::DATA_W-1:0]    m_axis_tdata,   // [9:0] pwm_duty, [10] drive_direction,
                                                          // [31:11] speed_now
    output logic                          m_axis_tlast,   // move_done
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [tsp_pkg::DATA_W-1:0]    pwdata,
    output logic [tsp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    logic signed [tsp_pkg::DIST_W-1:0] r_move_distance;
    logic [tsp_pkg::RAMP_W-1:0]        r_ramp_up_length;
    logic [tsp_pkg::RAMP_W-1:0]        r_ramp_down_length;
    logic signed [tsp_pkg::PEAK_W-1:0] r_peak_speed;

    tsp_pkg::t_cmd    w_cmd;
    tsp_pkg::t_status w_stat;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_distance    <= '0;
            r_ramp_up_length   <= '0;
            r_ramp_down_length <= '0;
            r_peak_speed       <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                tsp_pkg::REG_DIST:      r_move_distance    <= pwdata[tsp_pkg::DIST_W-1:0];
                tsp_pkg::REG_RAMP_UP:   r_ramp_up_length   <= pwdata[tsp_pkg::RAMP_W-1:0];
                tsp_pkg::REG_RAMP_DOWN: r_ramp_down_length <= pwdata[tsp_pkg::RAMP_W-1:0];
                tsp_pkg::REG_PEAK:      r_peak_speed       <= pwdata[tsp_pkg::PEAK_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tsp_pkg::REG_DIST:      prdata = tsp_pkg::DATA_W'(r_move_distance);
            tsp_pkg::REG_RAMP_UP:   prdata = tsp_pkg::DATA_W'(r_ramp_up_length);
            tsp_pkg::REG_RAMP_DOWN: prdata = tsp_pkg::DATA_W'(r_ramp_down_length);
            tsp_pkg::REG_PEAK:      prdata = tsp_pkg::DATA_W'(r_peak_speed);
        endcase
    end

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tsp_datapath #(
        .DUTY_FULL (DUTY_FULL),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_enc       ($signed(s_axis_tdata)),
        .i_dist      (r_move_distance),
        .i_ramp_up   (r_ramp_up_length),
        .i_ramp_down (r_ramp_down_length),
        .i_peak      (r_peak_speed),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

    // A tick in progress blocks the next input beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a tick was still in progress");

    // The divider is never restarted while it is still iterating.
    a_div_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider started while busy");

    // A result is only loaded when the output register can take it.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_stat.out_free && !s_axis_tready)
        else $error("result loaded over a pending output beat");

endmodule
